FILE: rtl/cdist_pkg.sv
package cdist_pkg;

   // Fixed formats
   localparam int SAMPLE_W     = 24;
   localparam int COEF_FRAC    = 16;
   localparam int SMOOTH_SHIFT = 9;
   localparam int TANH_DEPTH   = 256;
   localparam int TANH_IDX_W   = $clog2(TANH_DEPTH);
   localparam int NUM_CH       = 2;
   localparam int CH_W         = 1;
   localparam int NUM_SET      = 6;
   localparam int SET_W        = 23;
   localparam int DIV_NUM_W    = 43;
   localparam int QUO_W        = 27;
   localparam int CNT_W        = 5;

   localparam logic [16:0] COEF_ONE  = 17'd65536;
   localparam logic [16:0] TH_MIN    = 17'((65536 * 5 + 50) / 100);
   localparam logic [16:0] POST_COEF = 17'((13289575 + 128) >> 8);
   localparam logic signed [47:0] LIM_POS = 48'sd1073741824;
   localparam logic signed [47:0] LIM_NEG = -48'sd1073741824;

   // Register reset values
   localparam logic        RST_ENABLE     = 1'b1;
   localparam logic [22:0] RST_PRE_GAIN   = 23'd933888;
   localparam logic [16:0] RST_CLIP_LEVEL = 17'd39322;
   localparam logic [16:0] RST_OPAMP_COEF = 17'd36615;
   localparam logic [16:0] RST_TONE_COEF  = 17'd25159;
   localparam logic [16:0] RST_OUT_LEVEL  = 17'd65536;
   localparam logic [16:0] RST_WET_MIX    = 17'd65536;
   localparam logic [16:0] RST_HP_COEF    = 17'd65066;

   typedef logic signed [31:0] samp_type;

   typedef enum logic [2:0] {
      REG_ENABLE     = 3'd0,
      REG_PRE_GAIN   = 3'd1,
      REG_CLIP_LEVEL = 3'd2,
      REG_OPAMP_COEF = 3'd3,
      REG_TONE_COEF  = 3'd4,
      REG_OUT_LEVEL  = 3'd5,
      REG_WET_MIX    = 3'd6,
      REG_HP_COEF    = 3'd7
   } reg_addr_type;

   typedef struct packed {
      logic        enable;
      logic [22:0] pre_gain;
      logic [16:0] clip_level;
      logic [16:0] opamp_coef;
      logic [16:0] tone_coef;
      logic [16:0] out_level;
      logic [16:0] wet_mix;
      logic [16:0] hp_coef;
   } cfg_type;

   // Datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE, OP_SMOOTH, OP_X, OP_MUL_HP, OP_HP, OP_MUL_GAIN, OP_SAT_PROD,
      OP_MUL_OPAMP, OP_OPAMP, OP_DIV_START, OP_DIV_END, OP_MUL_POST, OP_POST,
      OP_MUL_TONE, OP_TONE, OP_MUL_LEVEL, OP_MUL_MIX, OP_MIX, OP_TANH_IDX,
      OP_TANH_MUL, OP_TANH_OUT
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [CH_W-1:0] ch;
      logic            load;
      logic            publish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   localparam logic [4:0] LAST_STEP = 5'd19;

   // Per-channel program
   function automatic op_type step_op(input logic [4:0] step);
      op_type op;
      case (step)
         5'd0:    op = OP_X;
         5'd1:    op = OP_MUL_HP;
         5'd2:    op = OP_HP;
         5'd3:    op = OP_MUL_GAIN;
         5'd4:    op = OP_SAT_PROD;
         5'd5:    op = OP_MUL_OPAMP;
         5'd6:    op = OP_OPAMP;
         5'd7:    op = OP_DIV_START;
         5'd8:    op = OP_DIV_END;
         5'd9:    op = OP_MUL_POST;
         5'd10:   op = OP_POST;
         5'd11:   op = OP_MUL_TONE;
         5'd12:   op = OP_TONE;
         5'd13:   op = OP_MUL_LEVEL;
         5'd14:   op = OP_SAT_PROD;
         5'd15:   op = OP_MUL_MIX;
         5'd16:   op = OP_MIX;
         5'd17:   op = OP_TANH_IDX;
         5'd18:   op = OP_TANH_MUL;
         5'd19:   op = OP_TANH_OUT;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

   // Saturate to +-16.0 in Q6.26
   function automatic samp_type sat16(input logic signed [47:0] v);
      logic signed [47:0] r;
      if (v > LIM_POS) begin
         r = LIM_POS;
      end else if (v < LIM_NEG) begin
         r = LIM_NEG;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

   // Coefficient limited to one
   function automatic logic signed [24:0] coef_cap(input logic [22:0] v);
      logic signed [24:0] r;
      if (v > 23'(COEF_ONE)) begin
         r = 25'(COEF_ONE);
      end else begin
         r = $signed({2'b00, v});
      end
      return r;
   endfunction

   // Shift-subtract quotient, used only while the table is built
   function automatic longint unsigned udiv(input longint unsigned n,
                                            input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh(4*i/(D-1)) in Q6.26 from an integer exp
   typedef logic [26:0] tanh_tab_type [TANH_DEPTH];

   function automatic logic [26:0] tanh_entry(input int unsigned i);
      longint unsigned one;
      longint unsigned a;
      longint unsigned t2;
      longint unsigned t3;
      longint unsigned t4;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      one = 64'd1 << 30;
      a   = udiv(64'(i) << 25, 64'(TANH_DEPTH - 1));
      t2  = (a * a) >> 30;
      t3  = (t2 * a) >> 30;
      t4  = (t3 * a) >> 30;
      e   = one - a + (t2 >> 1) - udiv(t3, 64'd6) + udiv(t4, 64'd24);
      for (int k = 0; k < 8; k++) begin
         e = (e * e + (one >> 1)) >> 30;
      end
      num = (one - e) << 26;
      den = one + e;
      return 27'(udiv(num + (den >> 1), den));
   endfunction

   function automatic tanh_tab_type tanh_build();
      tanh_tab_type t;
      for (int i = 0; i < TANH_DEPTH; i++) begin
         t[i] = tanh_entry(i);
      end
      return t;
   endfunction

   localparam tanh_tab_type TANH_TAB = tanh_build();

endpackage

FILE: rtl/cdist_if.sv
// Input frame channel
interface cdist_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cdist_pkg::SAMPLE_W-1:0]  left_sample;
   logic signed [cdist_pkg::SAMPLE_W-1:0]  right_sample;

   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// Result frame channel
interface cdist_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cdist_pkg::SAMPLE_W-1:0]  left_out;
   logic signed [cdist_pkg::SAMPLE_W-1:0]  right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

FILE: rtl/cdist_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits
module cdist_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [cdist_pkg::DIV_NUM_W-1:0]    num,
   input  logic [16:0]                        den,
   output logic                               done,
   output logic [cdist_pkg::QUO_W-1:0]        quo
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cdist_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [cdist_pkg::DIV_NUM_W-1:0]   rem_ff, rem_in;
   logic [16:0]                       den_ff, den_in;
   logic [cdist_pkg::QUO_W-1:0]       quo_ff, quo_in;
   logic [cdist_pkg::DIV_NUM_W:0]     shifted;
   logic [cdist_pkg::DIV_NUM_W:0]     trial;

   // One trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = (cdist_pkg::DIV_NUM_W+1)'(den_ff) << cnt_ff;
      trial   = {1'b0, rem_ff} - shifted;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = cdist_pkg::CNT_W'(cdist_pkg::QUO_W - 1);
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (!trial[cdist_pkg::DIV_NUM_W]) begin
            rem_in         = trial[cdist_pkg::DIV_NUM_W-1:0];
            quo_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: rtl/cdist_datapath.sv
// Shared multiplier datapath with per-channel filter state
module cdist_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cdist_pkg::cmd_type                    cmd,
   input  cdist_pkg::cfg_type                    cfg,
   input  logic signed [cdist_pkg::SAMPLE_W-1:0] req_left,
   input  logic signed [cdist_pkg::SAMPLE_W-1:0] req_right,
   output cdist_pkg::status_type                 status,
   output logic signed [cdist_pkg::SAMPLE_W-1:0] out_left,
   output logic signed [cdist_pkg::SAMPLE_W-1:0] out_right
);

   localparam int NC = cdist_pkg::NUM_CH;
   localparam int NS = cdist_pkg::NUM_SET;
   localparam int SW = cdist_pkg::SAMPLE_W;

   // Filter state
   cdist_pkg::samp_type hp_in_ff  [NC], hp_in_in  [NC];
   cdist_pkg::samp_type hp_out_ff [NC], hp_out_in [NC];
   cdist_pkg::samp_type opamp_ff  [NC], opamp_in  [NC];
   cdist_pkg::samp_type post_ff   [NC], post_in   [NC];
   cdist_pkg::samp_type tone_ff   [NC], tone_in   [NC];
   logic [cdist_pkg::SET_W-1:0] sm_ff [NS], sm_in [NS];

   // Working registers
   logic signed [SW-1:0] in_ff  [NC], in_in  [NC];
   logic signed [SW-1:0] res_ff [NC], res_in [NC];
   logic signed [SW-1:0] out_ff [NC], out_in [NC];
   cdist_pkg::samp_type  x_ff, x_in;
   cdist_pkg::samp_type  acc_ff, acc_in;
   logic signed [41:0]   prod_ff, prod_in;
   logic                 t_neg_ff, t_neg_in;
   logic                 t_top_ff, t_top_in;
   logic [cdist_pkg::TANH_IDX_W-1:0] t_idx_ff, t_idx_in;
   logic [25:0]          t_frac_ff, t_frac_in;
   logic [26:0]          t_base_ff, t_base_in;
   logic [26:0]          t_lin_ff, t_lin_in;

   // Combinational helpers
   logic signed [32:0]   mul_a;
   logic signed [24:0]   mul_c;
   logic signed [57:0]   mul_full;
   cdist_pkg::samp_type  s_val;
   logic [cdist_pkg::SET_W-1:0] tgt [NS];
   logic signed [23:0]   sd;
   logic signed [23:0]   st;
   logic signed [24:0]   ssum;
   logic [16:0]          th;
   logic [30:0]          mag;
   logic [26:0]          thq;
   logic [26:0]          magc;
   logic [cdist_pkg::DIV_NUM_W-1:0] div_num;
   logic                 div_start;
   logic [cdist_pkg::QUO_W-1:0] quo;
   logic                 div_done;
   logic [28:0]          tmag;
   logic [36:0]          tp;
   logic [26:0]          tdiff;
   logic [52:0]          tprod;
   logic [cdist_pkg::TANH_IDX_W:0] t_next;
   logic [27:0]          tr;
   logic signed [28:0]   trs;
   logic signed [28:0]   tro;

   // Clip threshold and divider operands
   always_comb begin
      if (sm_ff[1] < 23'(cdist_pkg::TH_MIN)) begin
         th = cdist_pkg::TH_MIN;
      end else if (sm_ff[1] > 23'(cdist_pkg::COEF_ONE)) begin
         th = cdist_pkg::COEF_ONE;
      end else begin
         th = sm_ff[1][16:0];
      end
      mag     = acc_ff[31] ? 31'(-acc_ff) : acc_ff[30:0];
      thq     = {th, 10'b0};
      magc    = (mag > 31'(thq)) ? thq : mag[26:0];
      div_num = {magc, 16'b0} + cdist_pkg::DIV_NUM_W'(th >> 1);
   end

   cdist_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (th),
      .done  (div_done),
      .quo   (quo)
   );

   assign status.div_done = div_done;

   // Smoothing targets
   always_comb begin
      tgt[0] = cfg.pre_gain;
      tgt[1] = 23'(cfg.clip_level);
      tgt[2] = 23'(cfg.opamp_coef);
      tgt[3] = 23'(cfg.tone_coef);
      tgt[4] = 23'(cfg.out_level);
      tgt[5] = 23'(cfg.wet_mix);
   end

   // Micro-operation decode
   always_comb begin
      hp_in_in  = hp_in_ff;
      hp_out_in = hp_out_ff;
      opamp_in  = opamp_ff;
      post_in   = post_ff;
      tone_in   = tone_ff;
      sm_in     = sm_ff;
      in_in     = in_ff;
      res_in    = res_ff;
      out_in    = out_ff;
      x_in      = x_ff;
      acc_in    = acc_ff;
      t_neg_in  = t_neg_ff;
      t_top_in  = t_top_ff;
      t_idx_in  = t_idx_ff;
      t_frac_in = t_frac_ff;
      t_base_in = t_base_ff;
      t_lin_in  = t_lin_ff;
      mul_a     = '0;
      mul_c     = '0;
      div_start = 1'b0;
      s_val     = '0;
      sd        = '0;
      st        = '0;
      ssum      = '0;
      tmag      = '0;
      tp        = '0;
      tdiff     = '0;
      tprod     = '0;
      t_next    = '0;
      tr        = '0;
      trs       = '0;
      tro       = '0;
      case (cmd.op)
         cdist_pkg::OP_SMOOTH: begin
            for (int k = 0; k < NS; k++) begin
               sd = $signed({1'b0, tgt[k]}) - $signed({1'b0, sm_ff[k]});
               if (sd >= 0) begin
                  st = sd >>> cdist_pkg::SMOOTH_SHIFT;
               end else begin
                  st = -((-sd) >>> cdist_pkg::SMOOTH_SHIFT);
               end
               ssum = 25'(sd - sd) + $signed({2'b00, sm_ff[k]}) + 25'(st);
               sm_in[k] = (st == 0) ? tgt[k] : ssum[cdist_pkg::SET_W-1:0];
            end
         end
         cdist_pkg::OP_X: begin
            x_in = {{5{in_ff[cmd.ch][SW-1]}}, in_ff[cmd.ch], 3'b000};
         end
         cdist_pkg::OP_MUL_HP: begin
            mul_a = 33'(hp_out_ff[cmd.ch]);
            mul_c = cdist_pkg::coef_cap(23'(cfg.hp_coef));
         end
         cdist_pkg::OP_HP: begin
            s_val = cdist_pkg::sat16(48'(x_ff) - 48'(hp_in_ff[cmd.ch]) + 48'(prod_ff));
            hp_in_in[cmd.ch]  = x_ff;
            hp_out_in[cmd.ch] = s_val;
            acc_in = s_val;
         end
         cdist_pkg::OP_MUL_GAIN: begin
            mul_a = 33'(acc_ff);
            mul_c = $signed({2'b00, sm_ff[0]});
         end
         cdist_pkg::OP_SAT_PROD: begin
            acc_in = cdist_pkg::sat16(48'(prod_ff));
         end
         cdist_pkg::OP_MUL_OPAMP: begin
            mul_a = 33'(acc_ff) - 33'(opamp_ff[cmd.ch]);
            mul_c = cdist_pkg::coef_cap(sm_ff[2]);
         end
         cdist_pkg::OP_OPAMP: begin
            s_val = cdist_pkg::sat16(48'(opamp_ff[cmd.ch]) + 48'(prod_ff));
            opamp_in[cmd.ch] = s_val;
            acc_in = s_val;
         end
         cdist_pkg::OP_DIV_START: begin
            div_start = 1'b1;
         end
         cdist_pkg::OP_DIV_END: begin
            acc_in = acc_ff[31] ? -$signed(32'(quo)) : $signed(32'(quo));
         end
         cdist_pkg::OP_MUL_POST: begin
            mul_a = 33'(acc_ff) - 33'(post_ff[cmd.ch]);
            mul_c = $signed({8'b0, cdist_pkg::POST_COEF});
         end
         cdist_pkg::OP_POST: begin
            s_val = cdist_pkg::sat16(48'(post_ff[cmd.ch]) + 48'(prod_ff));
            post_in[cmd.ch] = s_val;
            acc_in = s_val;
         end
         cdist_pkg::OP_MUL_TONE: begin
            mul_a = 33'(acc_ff) - 33'(tone_ff[cmd.ch]);
            mul_c = cdist_pkg::coef_cap(sm_ff[3]);
         end
         cdist_pkg::OP_TONE: begin
            s_val = cdist_pkg::sat16(48'(tone_ff[cmd.ch]) + 48'(prod_ff));
            tone_in[cmd.ch] = s_val;
            acc_in = s_val;
         end
         cdist_pkg::OP_MUL_LEVEL: begin
            mul_a = 33'(acc_ff);
            mul_c = $signed({2'b00, sm_ff[4]});
         end
         cdist_pkg::OP_MUL_MIX: begin
            mul_a = 33'(acc_ff) - 33'(x_ff);
            mul_c = cdist_pkg::coef_cap(sm_ff[5]);
         end
         cdist_pkg::OP_MIX: begin
            acc_in = cdist_pkg::sat16(48'(x_ff) + 48'(prod_ff));
         end
         cdist_pkg::OP_TANH_IDX: begin
            tmag = (mag > 31'(29'h1000_0000)) ? 29'h1000_0000 : mag[28:0];
            tp   = (37'(tmag) * 37'(cdist_pkg::TANH_DEPTH - 1)) >> 2;
            t_neg_in  = acc_ff[31];
            t_idx_in  = tp[26+cdist_pkg::TANH_IDX_W-1:26];
            t_frac_in = tp[25:0];
            t_top_in  = (tp[26+cdist_pkg::TANH_IDX_W-1:26] ==
                         cdist_pkg::TANH_IDX_W'(cdist_pkg::TANH_DEPTH - 1));
         end
         cdist_pkg::OP_TANH_MUL: begin
            t_next    = (cdist_pkg::TANH_IDX_W+1)'(t_idx_ff) + 1'b1;
            tdiff     = cdist_pkg::TANH_TAB[t_next[cdist_pkg::TANH_IDX_W-1:0]] -
                        cdist_pkg::TANH_TAB[t_idx_ff];
            tprod     = 53'(tdiff) * 53'(t_frac_ff);
            t_base_in = cdist_pkg::TANH_TAB[t_idx_ff];
            t_lin_in  = t_top_ff ? 27'd0 : tprod[52:26];
         end
         cdist_pkg::OP_TANH_OUT: begin
            // Round to Q1.23 and saturate
            tr  = 28'(t_base_ff) + 28'(t_lin_ff);
            trs = t_neg_ff ? -$signed({1'b0, tr}) : $signed({1'b0, tr});
            tro = (trs + 29'sd4) >>> 3;
            if (tro > 29'sd8388607) begin
               res_in[cmd.ch] = 24'sh7FFFFF;
            end else if (tro < -29'sd8388608) begin
               res_in[cmd.ch] = -24'sh800000;
            end else begin
               res_in[cmd.ch] = tro[SW-1:0];
            end
         end
         default: begin
         end
      endcase
      if (cmd.load) begin
         in_in[0] = req_left;
         in_in[1] = req_right;
      end
      if (cmd.publish) begin
         out_in = cfg.enable ? res_ff : in_ff;
      end
   end

   // Rounded coefficient product, registered every cycle
   always_comb begin
      mul_full = 58'(mul_a) * 58'(mul_c) + 58'sd32768;
      prod_in  = 42'(mul_full >>> cdist_pkg::COEF_FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            hp_in_ff[c]  <= '0;
            hp_out_ff[c] <= '0;
            opamp_ff[c]  <= '0;
            post_ff[c]   <= '0;
            tone_ff[c]   <= '0;
         end
         sm_ff[0] <= cdist_pkg::RST_PRE_GAIN;
         sm_ff[1] <= 23'(cdist_pkg::RST_CLIP_LEVEL);
         sm_ff[2] <= 23'(cdist_pkg::RST_OPAMP_COEF);
         sm_ff[3] <= 23'(cdist_pkg::RST_TONE_COEF);
         sm_ff[4] <= 23'(cdist_pkg::RST_OUT_LEVEL);
         sm_ff[5] <= 23'(cdist_pkg::RST_WET_MIX);
      end else begin
         hp_in_ff  <= hp_in_in;
         hp_out_ff <= hp_out_in;
         opamp_ff  <= opamp_in;
         post_ff   <= post_in;
         tone_ff   <= tone_in;
         sm_ff     <= sm_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff     <= in_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
      x_ff      <= x_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      t_neg_ff  <= t_neg_in;
      t_top_ff  <= t_top_in;
      t_idx_ff  <= t_idx_in;
      t_frac_ff <= t_frac_in;
      t_base_ff <= t_base_in;
      t_lin_ff  <= t_lin_in;
   end

   assign out_left  = out_ff[0];
   assign out_right = out_ff[1];

endmodule

FILE: rtl/cdist_ctrl.sv
// Frame sequencer: smoothing, per-channel program, divider wait, result hand-off
module cdist_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  enable,
   input  cdist_pkg::status_type status,
   output cdist_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SMOOTH = 5'b00010,
      ST_RUN    = 5'b00100,
      ST_WAIT   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [4:0]                 step_ff, step_in;
   logic [cdist_pkg::CH_W-1:0] ch_ff, ch_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cdist_pkg::op_type          prog_op;

   assign prog_op = cdist_pkg::step_op(step_ff);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = cdist_pkg::OP_NONE;
      cmd.ch       = ch_ff;
      cmd.load     = 1'b0;
      cmd.publish  = 1'b0;
      req_ready    = (state_ff == ST_IDLE);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = enable ? ST_SMOOTH : ST_DONE;
            end
         end
         ST_SMOOTH: begin
            cmd.op   = cdist_pkg::OP_SMOOTH;
            step_in  = '0;
            ch_in    = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.op = prog_op;
            if (prog_op == cdist_pkg::OP_DIV_START) begin
               step_in  = step_ff + 1'b1;
               state_in = ST_WAIT;
            end else if (step_ff == cdist_pkg::LAST_STEP) begin
               step_in = '0;
               if (ch_ff == cdist_pkg::CH_W'(cdist_pkg::NUM_CH - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (status.div_done) begin
               state_in = ST_RUN;
            end
         end
         ST_DONE: begin
            // result register free or emptying this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_WAIT)
      else $error("divider finished outside of wait state");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published word not presented");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= cdist_pkg::LAST_STEP)
      else $error("program step out of range");

endmodule

FILE: rtl/clipping_distortion_stereo.sv
// Stereo hard-clip distortion.
// req carries one stereo frame (left_sample, right_sample, signed Q1.23);
// rsp returns one processed frame per accepted word, in order.
// Settings are written over the APB-style port (4-byte stride, index 0..7)
// only while no frame is in flight: the user must keep to this, the block
// does not enforce it. Reads return the written values.
// With enable set, an accepted frame goes through a smoothing step, then per
// channel 20 program steps on one shared multiplier plus a wait on the
// 27-bit bit-serial clip divider (channels in turn), then a hand-off step
// into the output register. With enable clear the dry frame passes through
// the done state to the output register. A new frame is accepted only once
// the previous one has been handed off, and may be accepted while that
// result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// finished frame after it waits until that register is taken.
// Reset restores register defaults, clears filter state and returns the
// smoothed settings to the register defaults.
module clipping_distortion_stereo (
   input  logic               clock,
   input  logic               reset,
   cdist_req_if.sink          req,
   cdist_rsp_if.source        rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cdist_pkg::cfg_type    cfg_ff, cfg_in;
   cdist_pkg::cmd_type    cmd;
   cdist_pkg::status_type status;
   logic                  csr_wr;

   // Register writes
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (cdist_pkg::reg_addr_type'(paddr[4:2]))
            cdist_pkg::REG_ENABLE:     cfg_in.enable     = pwdata[0];
            cdist_pkg::REG_PRE_GAIN:   cfg_in.pre_gain   = pwdata[22:0];
            cdist_pkg::REG_CLIP_LEVEL: cfg_in.clip_level = pwdata[16:0];
            cdist_pkg::REG_OPAMP_COEF: cfg_in.opamp_coef = pwdata[16:0];
            cdist_pkg::REG_TONE_COEF:  cfg_in.tone_coef  = pwdata[16:0];
            cdist_pkg::REG_OUT_LEVEL:  cfg_in.out_level  = pwdata[16:0];
            cdist_pkg::REG_WET_MIX:    cfg_in.wet_mix    = pwdata[16:0];
            cdist_pkg::REG_HP_COEF:    cfg_in.hp_coef    = pwdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (cdist_pkg::reg_addr_type'(paddr[4:2]))
         cdist_pkg::REG_ENABLE:     prdata = 32'(cfg_ff.enable);
         cdist_pkg::REG_PRE_GAIN:   prdata = 32'(cfg_ff.pre_gain);
         cdist_pkg::REG_CLIP_LEVEL: prdata = 32'(cfg_ff.clip_level);
         cdist_pkg::REG_OPAMP_COEF: prdata = 32'(cfg_ff.opamp_coef);
         cdist_pkg::REG_TONE_COEF:  prdata = 32'(cfg_ff.tone_coef);
         cdist_pkg::REG_OUT_LEVEL:  prdata = 32'(cfg_ff.out_level);
         cdist_pkg::REG_WET_MIX:    prdata = 32'(cfg_ff.wet_mix);
         cdist_pkg::REG_HP_COEF:    prdata = 32'(cfg_ff.hp_coef);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= cdist_pkg::RST_ENABLE;
         cfg_ff.pre_gain   <= cdist_pkg::RST_PRE_GAIN;
         cfg_ff.clip_level <= cdist_pkg::RST_CLIP_LEVEL;
         cfg_ff.opamp_coef <= cdist_pkg::RST_OPAMP_COEF;
         cfg_ff.tone_coef  <= cdist_pkg::RST_TONE_COEF;
         cfg_ff.out_level  <= cdist_pkg::RST_OUT_LEVEL;
         cfg_ff.wet_mix    <= cdist_pkg::RST_WET_MIX;
         cfg_ff.hp_coef    <= cdist_pkg::RST_HP_COEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cdist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .enable    (cfg_ff.enable),
      .status    (status),
      .cmd       (cmd)
   );

   cdist_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .req_left  (req.left_sample),
      .req_right (req.right_sample),
      .status    (status),
      .out_left  (rsp.left_out),
      .out_right (rsp.right_out)
   );

endmodule

FILE: verif/cdist_checker.sv
`timescale 1ns / 100ps

// Watches the frame channels and the register port, predicts every result
// frame and compares it with what the block returns.
module cdist_checker (
   input  logic        clock,
   input  logic        reset,
   cdist_req_if        req,
   cdist_rsp_if        rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          errors,
   output int          frames_due
);

   localparam longint UNITY   = 65536;
   localparam longint RAIL    = 64'sd1 << 30;
   localparam longint LP12K   = 51912;
   localparam longint CLIP_LO = 3277;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } frame_type;

   frame_type      frames_ahead[$];
   longint         shadow_reg[8];
   longint         glide[6];
   longint         dc_in[2], dc_out[2], opamp_st[2], post_st[2], tone_st[2];
   longint         tanh_lut[256];

   // tanh(4i/255) in Q6.26 by a squared Taylor exp
   initial begin
      longint unsigned u, a, t2, t3, t4, e, num, den;
      u = 64'd1 << 30;
      for (int i = 0; i < 256; i++) begin
         a  = (64'(i) << 25) / 255;
         t2 = (a * a) >> 30;
         t3 = (t2 * a) >> 30;
         t4 = (t3 * a) >> 30;
         e  = u - a + t2 / 2 - t3 / 6 + t4 / 24;
         for (int k = 0; k < 8; k++) e = (e * e + (u >> 1)) >> 30;
         num = (u - e) << 26;
         den = u + e;
         tanh_lut[i] = longint'((num + den / 2) / den);
      end
   end

   function automatic longint scale_q16(longint a, longint c);
      return (a * c + 32768) >>> 16;
   endfunction

   function automatic longint rail16(longint v);
      return v > RAIL ? RAIL : (v < -RAIL ? -RAIL : v);
   endfunction

   function automatic longint unity_cap(longint c);
      return c > UNITY ? UNITY : c;
   endfunction

   function automatic longint tanh_shape(longint m);
      longint mag, p, idx, frac, r;
      mag = m < 0 ? -m : m;
      if (mag > (64'sd1 << 28)) mag = 64'sd1 << 28;
      p    = (mag * 255) >> 2;
      idx  = p >> 26;
      frac = p & ((64'sd1 << 26) - 1);
      if (idx >= 255) r = tanh_lut[255];
      else r = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * frac) >> 26);
      return m < 0 ? -r : r;
   endfunction

   function automatic longint clip_scale(longint v, longint th);
      longint mag, q;
      if (th < CLIP_LO) th = CLIP_LO;
      if (th > UNITY) th = UNITY;
      mag = v < 0 ? -v : v;
      if (mag > (th << 10)) mag = th << 10;
      q = (mag * UNITY + th / 2) / th;
      return v < 0 ? -q : q;
   endfunction

   // One channel through the whole effect chain, Q1.23 in and out
   function automatic logic signed [23:0] distort(int c, logic signed [23:0] smp);
      longint x, y, w, s, o;
      x = longint'(smp) * 8;
      y = rail16(x - dc_in[c] +
                 scale_q16(dc_out[c], unity_cap(shadow_reg[cdist_pkg::REG_HP_COEF])));
      dc_in[c]  = x;
      dc_out[c] = y;
      w = rail16(scale_q16(y, glide[0]));
      s = rail16(opamp_st[c] + scale_q16(w - opamp_st[c], unity_cap(glide[2])));
      opamp_st[c] = s;
      w = clip_scale(s, glide[1]);
      s = rail16(post_st[c] + scale_q16(w - post_st[c], LP12K));
      post_st[c] = s;
      s = rail16(tone_st[c] + scale_q16(s - tone_st[c], unity_cap(glide[3])));
      tone_st[c] = s;
      w = rail16(scale_q16(s, glide[4]));
      w = rail16(x + scale_q16(w - x, unity_cap(glide[5])));
      o = (tanh_shape(w) + 4) >>> 3;
      if (o > 8388607) o = 8388607;
      if (o < -8388608) o = -8388608;
      return o[23:0];
   endfunction

   function automatic frame_type predict_frame(logic signed [23:0] l, logic signed [23:0] r);
      frame_type f;
      longint d, st;
      if (shadow_reg[cdist_pkg::REG_ENABLE] == 0) begin
         f.left  = l;
         f.right = r;
         return f;
      end
      // settings glide toward their targets
      for (int i = 0; i < 6; i++) begin
         d  = shadow_reg[i+1] - glide[i];
         st = d >= 0 ? (d >> cdist_pkg::SMOOTH_SHIFT) : -((-d) >> cdist_pkg::SMOOTH_SHIFT);
         glide[i] = st == 0 ? shadow_reg[i+1] : glide[i] + st;
      end
      f.left  = distort(0, l);
      f.right = distort(1, r);
      return f;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("%0t: mismatch %s: got %0d expected %0d", $time, what, got, want);
   endtask

   initial begin
      errors     = 0;
      frames_due = 0;
   end

   always @(posedge clock) begin
      frame_type f;
      int        idx;
      if (reset) begin
         shadow_reg = '{1, 933888, 39322, 36615, 25159, 65536, 65536, 65066};
         for (int i = 0; i < 6; i++) glide[i] = shadow_reg[i+1];
         for (int c = 0; c < 2; c++) begin
            dc_in[c] = 0; dc_out[c] = 0; opamp_st[c] = 0; post_st[c] = 0; tone_st[c] = 0;
         end
         frames_ahead.delete();
      end else begin
         // register write, masked to width
         if (psel && penable && pwrite && pready) begin
            idx = paddr[4:2];
            if (idx == cdist_pkg::REG_ENABLE) shadow_reg[idx] = pwdata[0];
            else if (idx == cdist_pkg::REG_PRE_GAIN) shadow_reg[idx] = pwdata[22:0];
            else shadow_reg[idx] = pwdata[16:0];
         end
         if (req.valid && req.ready)
            frames_ahead.push_back(predict_frame(req.left_sample, req.right_sample));
         if (rsp.valid && rsp.ready) begin
            if (frames_ahead.size() == 0) begin
               report("unexpected word", rsp.left_out, 0);
            end else begin
               f = frames_ahead.pop_front();
               if (rsp.left_out !== f.left) report("left_out", rsp.left_out, f.left);
               if (rsp.right_out !== f.right) report("right_out", rsp.right_out, f.right);
            end
         end
      end
      frames_due = frames_ahead.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        quiet;
   int          errors;
   int          frames_due;

   cdist_req_if req_ch ();
   cdist_rsp_if rsp_ch ();

   clipping_distortion_stereo uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cdist_checker chk (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .frames_due(frames_due)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver stalls in bursts
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ch.ready = 1;
      end
   end

   task automatic reg_write(cdist_pkg::reg_addr_type r, logic [31:0] v);
      psel = 1; penable = 0; pwrite = 1; paddr = {r, 2'b00}; pwdata = v;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   task automatic set_all(logic [31:0] en, logic [31:0] pg, logic [31:0] cl,
                          logic [31:0] oc, logic [31:0] tc, logic [31:0] ol,
                          logic [31:0] wm, logic [31:0] hp);
      reg_write(cdist_pkg::REG_ENABLE, en);
      reg_write(cdist_pkg::REG_PRE_GAIN, pg);
      reg_write(cdist_pkg::REG_CLIP_LEVEL, cl);
      reg_write(cdist_pkg::REG_OPAMP_COEF, oc);
      reg_write(cdist_pkg::REG_TONE_COEF, tc);
      reg_write(cdist_pkg::REG_OUT_LEVEL, ol);
      reg_write(cdist_pkg::REG_WET_MIX, wm);
      reg_write(cdist_pkg::REG_HP_COEF, hp);
   endtask

   // Present one word at a falling edge, hold until taken
   task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.left_sample = l;
      req_ch.right_sample = r;
      forever begin
         #1;
         if (req_ch.ready) break;
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   // Wait until every frame in flight has come back
   task automatic drain();
      req_ch.valid = 0;
      while (frames_due != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [23:0] rand_sample();
      logic signed [23:0] s;
      s = 24'($urandom);
      if ($urandom_range(0, 1)) s = s >>> $urandom_range(0, 23);
      return s;
   endfunction

   initial begin
      quiet = 0;
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      req_ch.valid = 0;
      req_ch.left_sample = 0;
      req_ch.right_sample = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings: full-scale and sign extremes
      send_frame(24'sh7fffff, -24'sh800000);
      send_frame(-24'sh800000, 24'sh7fffff);
      repeat (3) send_frame(24'sh7fffff, 24'sh7fffff);
      repeat (3) send_frame(-24'sh800000, -24'sh800000);
      send_frame(1, -1);
      send_frame(0, 0);
      drain();

      // coefficients above one, threshold clamped low, gain at its top
      set_all(1, 32'h7fffff, 0, 32'h1ffff, 32'h1ffff, 32'h1ffff, 32'h1ffff, 32'h1ffff);
      repeat (3) send_frame(24'sh7fffff, -24'sh800000);
      send_frame(0, 24'sh400000);
      drain();
      // threshold above one, all coefficients zero
      set_all(1, 0, 32'h1ffff, 0, 0, 0, 0, 0);
      repeat (3) send_frame(-24'sh800000, 24'sh7fffff);
      drain();
      // bypass
      reg_write(cdist_pkg::REG_ENABLE, 0);
      send_frame(24'sh7fffff, -24'sh800000);
      send_frame(24'sh123456, -24'sh654321);
      drain();

      // random phases; the sender waits for an empty pipe between them
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) begin
            quiet = 1;
            set_all(1, 933888, 39322, 36615, 25159, 65536, 65536, 65066);
         end else if (ph == 0) begin
            set_all(1, 131072, 3277, 36615, 25159, 98304, 32768, 65066);
         end else begin
            set_all(32'($urandom_range(0, 5) != 0), $urandom_range(0, 32'h7fffff),
                    $urandom_range(0, 32'h1ffff), $urandom_range(0, 32'h1ffff),
                    $urandom_range(0, 32'h1ffff), $urandom_range(0, 32'h1ffff),
                    $urandom_range(0, 32'h1ffff), $urandom_range(60000, 65536));
         end
         for (int n = 0; n < 116; n++) send_frame(rand_sample(), rand_sample());
         drain();
      end

      repeat (20) @(negedge clock);
      if (errors == 0 && frames_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
